[design/tup_pkg.sv]
// ----------------------------------------------------------------------------
// tup_pkg: shared types and constants of the text to uint64 parser
// Character codes, radix and mode codes, parser state and result records,
// and the digit decode helpers.
// ----------------------------------------------------------------------------
package tup_pkg;

	// Parser phase within one string
	typedef enum logic [2:0] {
		PH_SPACE  = 3'd0,
		PH_SIGNED = 3'd1,
		PH_ZERO   = 3'd2,
		PH_DIGITS = 3'd3,
		PH_DONE   = 3'd4
	} phase_t;

	// Radix codes as reported on radix_used
	localparam logic [1:0] RX_BIN = 2'd0;
	localparam logic [1:0] RX_OCT = 2'd1;
	localparam logic [1:0] RX_DEC = 2'd2;
	localparam logic [1:0] RX_HEX = 2'd3;

	// Base mode codes; anything above MODE_HEX is invalid
	localparam logic [2:0] MODE_AUTO = 3'd0;
	localparam logic [2:0] MODE_BIN  = 3'd1;
	localparam logic [2:0] MODE_OCT  = 3'd2;
	localparam logic [2:0] MODE_DEC  = 3'd3;
	localparam logic [2:0] MODE_HEX  = 3'd4;

	// Character codes
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UB    = 8'h42;
	localparam logic [7:0] CH_UF    = 8'h46;
	localparam logic [7:0] CH_UX    = 8'h58;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LB    = 8'h62;
	localparam logic [7:0] CH_LF    = 8'h66;
	localparam logic [7:0] CH_LX    = 8'h78;

	// Digit value that marks "not a digit"
	localparam logic [4:0] NO_DIGIT = 5'd16;

	// Running state of one string; nacc tracks the two's complement of acc
	typedef struct packed {
		phase_t      phase;
		logic [63:0] acc;
		logic [63:0] nacc;
		logic        negative;
		logic [1:0]  radix;
		logic [2:0]  held_mode;
	} parse_state_t;

	// One parsed result
	typedef struct packed {
		logic [63:0] value;
		logic [1:0]  radix_used;
		logic        bad_base;
	} parse_result_t;

	// Radix selected by an explicit mode; auto and invalid fall to decimal
	function automatic logic [1:0] mode_radix(input logic [2:0] mode);
		logic [1:0] rx;
		case (mode)
			MODE_BIN: rx = RX_BIN;
			MODE_OCT: rx = RX_OCT;
			MODE_HEX: rx = RX_HEX;
			default:  rx = RX_DEC;
		endcase
		return rx;
	endfunction

	// Number of digit values of a radix
	function automatic logic [4:0] radix_limit(input logic [1:0] rx);
		logic [4:0] lim;
		case (rx)
			RX_BIN:  lim = 5'd2;
			RX_OCT:  lim = 5'd8;
			RX_DEC:  lim = 5'd10;
			default: lim = 5'd16;
		endcase
		return lim;
	endfunction

	// Digit value of a character in a radix, NO_DIGIT when it is none
	function automatic logic [4:0] digit_of(input logic [7:0] c, input logic [1:0] rx);
		logic [7:0] d;
		d = {3'b000, NO_DIGIT};
		if (c >= CH_ZERO && c <= CH_NINE) begin
			d = c - CH_ZERO;
		end else if (c >= CH_LA && c <= CH_LF) begin
			d = c - CH_LA + 8'd10;
		end else if (c >= CH_UA && c <= CH_UF) begin
			d = c - CH_UA + 8'd10;
		end
		if (d[4:0] >= radix_limit(rx)) begin
			d = {3'b000, NO_DIGIT};
		end
		return d[4:0];
	endfunction

endpackage

[design/tup_if.sv]
// ----------------------------------------------------------------------------
// tup_if: valid/ready channels of the text to uint64 parser
// tup_char_if carries one character word, tup_result_if one parsed value.
// ----------------------------------------------------------------------------
interface tup_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] ch;
	logic [2:0] base_mode;
	logic       first;
	logic       last;

	modport source (output valid, ch, base_mode, first, last, input ready);
	modport sink   (input valid, ch, base_mode, first, last, output ready);
endinterface

interface tup_result_if;
	logic        valid;
	logic        ready;
	logic [63:0] value;
	logic [1:0]  radix_used;
	logic        bad_base;

	modport source (output valid, value, radix_used, bad_base, input ready);
	modport sink   (input valid, value, radix_used, bad_base, output ready);
endinterface

[design/tup_next.sv]
// ----------------------------------------------------------------------------
// tup_next: one-character step of the parser
// From the current string state and one character, forms the next state and
// the result that a last character reports.
// ----------------------------------------------------------------------------
module tup_next (
	input  tup_pkg::parse_state_t  cur,
	input  logic [7:0]             ch,
	input  logic [2:0]             base_mode,
	input  logic                   first,
	input  logic                   last,
	output tup_pkg::parse_state_t  nxt,
	output tup_pkg::parse_result_t res
);

	tup_pkg::parse_state_t st;
	tup_pkg::parse_state_t upd;
	logic                  after_sign;
	logic                  take;
	logic                  is_auto;
	logic                  is_x;
	logic                  is_b;
	logic                  is_ws;
	logic [4:0]            dig;
	logic [63:0]           acc_sc;
	logic [63:0]           nacc_sc;

	// Start of string: clear and latch the base mode
	always_comb begin
		st = cur;
		if (first) begin
			st.phase     = tup_pkg::PH_SPACE;
			st.acc       = '0;
			st.nacc      = '0;
			st.negative  = 1'b0;
			st.held_mode = base_mode;
			st.radix     = tup_pkg::mode_radix(base_mode);
		end
	end

	assign is_auto = (st.held_mode == tup_pkg::MODE_AUTO);
	assign is_x    = (ch == tup_pkg::CH_LX) || (ch == tup_pkg::CH_UX);
	assign is_b    = (ch == tup_pkg::CH_LB) || (ch == tup_pkg::CH_UB);
	assign is_ws   = (ch == tup_pkg::CH_SPACE) || (ch >= tup_pkg::CH_TAB && ch <= tup_pkg::CH_CR);

	// Phase decode, prefix handling and digit accumulation
	always_comb begin
		upd        = st;
		after_sign = 1'b0;
		take       = 1'b0;
		dig        = tup_pkg::NO_DIGIT;
		acc_sc     = '0;
		nacc_sc    = '0;
		case (st.phase)
			tup_pkg::PH_SPACE: begin
				if (is_ws) begin
					upd.phase = tup_pkg::PH_SPACE;
				end else if (ch == tup_pkg::CH_MINUS) begin
					upd.negative = 1'b1;
					upd.phase    = tup_pkg::PH_SIGNED;
				end else if (ch == tup_pkg::CH_PLUS) begin
					upd.phase = tup_pkg::PH_SIGNED;
				end else begin
					after_sign = 1'b1;
				end
			end
			tup_pkg::PH_SIGNED: begin
				after_sign = 1'b1;
			end
			tup_pkg::PH_ZERO: begin
				if (is_auto && is_x) begin
					upd.radix = tup_pkg::RX_HEX;
					upd.phase = tup_pkg::PH_DIGITS;
				end else if (is_auto && is_b) begin
					upd.radix = tup_pkg::RX_BIN;
					upd.phase = tup_pkg::PH_DIGITS;
				end else if ((st.held_mode == tup_pkg::MODE_HEX && is_x) ||
				             (st.held_mode == tup_pkg::MODE_BIN && is_b)) begin
					upd.phase = tup_pkg::PH_DIGITS;
				end else begin
					take = 1'b1;
				end
			end
			tup_pkg::PH_DIGITS: begin
				take = 1'b1;
			end
			default: begin
				upd.phase = tup_pkg::PH_DONE;
			end
		endcase

		// First character after the optional sign picks the radix in auto mode
		if (after_sign) begin
			if (ch == tup_pkg::CH_ZERO) begin
				if (is_auto) upd.radix = tup_pkg::RX_OCT;
				upd.phase = tup_pkg::PH_ZERO;
			end else begin
				if (is_auto) upd.radix = tup_pkg::RX_DEC;
				take = 1'b1;
			end
		end

		// Shift-add by the radix on both the value and its negation
		if (take) begin
			dig = tup_pkg::digit_of(ch, upd.radix);
			case (upd.radix)
				tup_pkg::RX_BIN: begin
					acc_sc  = {upd.acc[62:0], 1'b0};
					nacc_sc = {upd.nacc[62:0], 1'b0};
				end
				tup_pkg::RX_OCT: begin
					acc_sc  = {upd.acc[60:0], 3'b000};
					nacc_sc = {upd.nacc[60:0], 3'b000};
				end
				tup_pkg::RX_DEC: begin
					acc_sc  = {upd.acc[60:0], 3'b000} + {upd.acc[62:0], 1'b0};
					nacc_sc = {upd.nacc[60:0], 3'b000} + {upd.nacc[62:0], 1'b0};
				end
				default: begin
					acc_sc  = {upd.acc[59:0], 4'b0000};
					nacc_sc = {upd.nacc[59:0], 4'b0000};
				end
			endcase
			if (dig != tup_pkg::NO_DIGIT) begin
				upd.acc   = acc_sc + {59'd0, dig};
				upd.nacc  = nacc_sc - {59'd0, dig};
				upd.phase = tup_pkg::PH_DIGITS;
			end else begin
				upd.phase = tup_pkg::PH_DONE;
			end
		end
	end

	// Result fields and end-of-string clear
	always_comb begin
		res.bad_base = (upd.held_mode > tup_pkg::MODE_HEX);
		if (res.bad_base) begin
			res.value      = '0;
			res.radix_used = tup_pkg::RX_BIN;
		end else begin
			res.value = upd.negative ? upd.nacc : upd.acc;
			if (is_auto && (upd.phase == tup_pkg::PH_SPACE || upd.phase == tup_pkg::PH_SIGNED)) begin
				res.radix_used = tup_pkg::RX_DEC;
			end else begin
				res.radix_used = upd.radix;
			end
		end

		nxt = upd;
		if (last) begin
			nxt.phase    = tup_pkg::PH_SPACE;
			nxt.acc      = '0;
			nxt.nacc     = '0;
			nxt.negative = 1'b0;
		end
	end

endmodule

[design/text_to_uint64_parser.sv]
// ----------------------------------------------------------------------------
// text_to_uint64_parser: string to unsigned 64-bit integer converter
// Parses a character stream in the manner of strtoull with base detection.
// ----------------------------------------------------------------------------
// Usage:
//   chars  (sink) takes one character word per cycle while not stalled,
//          with base_mode, first and last. base_mode is latched on first.
//   result (source) gives one word per string, after the word marked last:
//          value (negated two's complement on a minus sign), radix_used and
//          bad_base (value 0 when the latched mode is invalid).
// Path: an accepted last character is held in the input register, passes the
//   parse step and lands in the result register, which drives result valid.
// Throughput: one character per cycle while no last character is stalled,
//   set by the single parse step between the input and result registers.
// Stall: the input register and the result register each hold one word;
//   characters that produce no result keep flowing while a result waits, and
//   a last character stalls in the input register only while the result
//   register is still full.
// Reset: empties both registers and returns the parser to whitespace skip in
//   auto mode with a zero value.
// ----------------------------------------------------------------------------
module text_to_uint64_parser (
	input  logic               clk,
	input  logic               arst_n,
	tup_char_if.sink           chars,
	tup_result_if.source       result
);

	// Input register
	logic       valid_s1;
	logic [7:0] ch_s1;
	logic [2:0] mode_s1;
	logic       first_s1;
	logic       last_s1;

	// Parser state and result register
	tup_pkg::parse_state_t  state_q;
	tup_pkg::parse_state_t  state_nxt;
	tup_pkg::parse_result_t res_nxt;
	tup_pkg::parse_result_t res_q;
	logic                   out_valid_q;

	logic out_free;
	logic s1_adv;

	assign out_free     = !out_valid_q || result.ready;
	assign s1_adv       = valid_s1 && (!last_s1 || out_free);
	assign chars.ready  = !valid_s1 || s1_adv;

	// Input register load
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (chars.ready) begin
			valid_s1 <= chars.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (chars.ready && chars.valid) begin
			ch_s1    <= chars.ch;
			mode_s1  <= chars.base_mode;
			first_s1 <= chars.first;
			last_s1  <= chars.last;
		end
	end

	// Parse step
	tup_next u_next (
		.cur       (state_q),
		.ch        (ch_s1),
		.base_mode (mode_s1),
		.first     (first_s1),
		.last      (last_s1),
		.nxt       (state_nxt),
		.res       (res_nxt)
	);

	// String state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase     <= tup_pkg::PH_SPACE;
			state_q.acc       <= '0;
			state_q.nacc      <= '0;
			state_q.negative  <= 1'b0;
			state_q.radix     <= tup_pkg::RX_BIN;
			state_q.held_mode <= tup_pkg::MODE_AUTO;
		end else if (s1_adv) begin
			state_q <= state_nxt;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= s1_adv && last_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && last_s1) begin
			res_q <= res_nxt;
		end
	end

	assign result.valid      = out_valid_q;
	assign result.value      = res_q.value;
	assign result.radix_used = res_q.radix_used;
	assign result.bad_base   = res_q.bad_base;

endmodule

[design/tup_checker.sv]
// ----------------------------------------------------------------------------
// tup_checker: port-level checks of the text to uint64 parser
// Watches both channels and checks result ordering and content rules.
// ----------------------------------------------------------------------------
module tup_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        in_last,
	input logic        out_valid,
	input logic        out_ready,
	input logic [63:0] out_value,
	input logic [1:0]  out_radix,
	input logic        out_bad
);

	// A pending result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result word dropped before handshake");

	// A stalled result keeps its payload
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_value) && $stable(out_radix) && $stable(out_bad))
		else $error("result word changed while stalled");

	// An invalid base reports zero in binary code
	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_bad |-> (out_value == 64'd0) && (out_radix == tup_pkg::RX_BIN))
		else $error("bad base result is not zero");

	// A fresh result follows a last character accepted through the input register
	a_rise_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready && in_last, 2))
		else $error("result without a last character");

endmodule

bind text_to_uint64_parser tup_checker u_tup_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (chars.valid),
	.in_ready  (chars.ready),
	.in_last   (chars.last),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.out_value (result.value),
	.out_radix (result.radix_used),
	.out_bad   (result.bad_base)
);

[tb/tb_text_to_uint64_parser.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_text_to_uint64_parser: self-checking testbench of the text parser
// Drives character words through the chars channel, mirrors the parse in a
// scoreboard that predicts each result word, and checks every result word
// field by field under several idle and stall patterns, one long result
// hold-off and full drains between phases.
// ----------------------------------------------------------------------------

// One character word as offered on the chars channel
typedef struct packed {
	logic [7:0] ch;
	logic [2:0] mode;
	logic       first;
	logic       last;
} char_word_t;

// Number of digit values in a radix
function automatic int unsigned radix_count(logic [1:0] rx);
	case (rx)
		tup_pkg::RX_BIN: return 2;
		tup_pkg::RX_OCT: return 8;
		tup_pkg::RX_DEC: return 10;
		default:         return 16;
	endcase
endfunction

// Parse mirror plus queue of expected result words
class parse_scoreboard;
	tup_pkg::phase_t        ph;
	logic [63:0]            acc;
	logic                   neg;
	logic [1:0]             rx;
	logic [2:0]             held;
	tup_pkg::parse_result_t expected[$];
	int                     errors;

	function new();
		ph = tup_pkg::PH_SPACE;
		acc = '0;
		neg = 1'b0;
		rx = tup_pkg::RX_BIN;
		held = tup_pkg::MODE_AUTO;
		errors = 0;
	endfunction

	function void clear_string();
		ph = tup_pkg::PH_SPACE;
		acc = '0;
		neg = 1'b0;
	endfunction

	// Digit weight of c in the active radix, 16 when it is not a digit
	function int unsigned digit_weight(logic [7:0] c);
		int unsigned d;
		d = 16;
		if (c >= tup_pkg::CH_ZERO && c <= tup_pkg::CH_NINE) begin
			d = c - tup_pkg::CH_ZERO;
		end else if (c >= tup_pkg::CH_LA && c <= tup_pkg::CH_LF) begin
			d = c - tup_pkg::CH_LA + 10;
		end else if (c >= tup_pkg::CH_UA && c <= tup_pkg::CH_UF) begin
			d = c - tup_pkg::CH_UA + 10;
		end
		if (d >= radix_count(rx)) d = 16;
		return d;
	endfunction

	// Accumulate one digit or stop the number
	function void shift_in(logic [7:0] c);
		int unsigned d;
		d = digit_weight(c);
		if (d < 16) begin
			acc = acc * 64'(radix_count(rx)) + 64'(d);
			ph = tup_pkg::PH_DIGITS;
		end else begin
			ph = tup_pkg::PH_DONE;
		end
	endfunction

	// First character after the optional sign
	function void lead_char(logic [7:0] c);
		if (c == tup_pkg::CH_ZERO) begin
			if (held == tup_pkg::MODE_AUTO) rx = tup_pkg::RX_OCT;
			ph = tup_pkg::PH_ZERO;
		end else begin
			if (held == tup_pkg::MODE_AUTO) rx = tup_pkg::RX_DEC;
			shift_in(c);
		end
	endfunction

	function int pending();
		return expected.size();
	endfunction

	task report(string msg);
		errors++;
		if (errors <= 40) $display("ERROR @%0t: %s", $time, msg);
	endtask

	// Advance the mirror by one accepted character word
	function void note_char(logic [7:0] c, logic [2:0] mode, logic first, logic last);
		tup_pkg::parse_result_t r;
		logic                   is_x;
		logic                   is_b;
		is_x = (c == tup_pkg::CH_LX || c == tup_pkg::CH_UX);
		is_b = (c == tup_pkg::CH_LB || c == tup_pkg::CH_UB);
		if (first) begin
			clear_string();
			held = mode;
			case (mode)
				tup_pkg::MODE_BIN: rx = tup_pkg::RX_BIN;
				tup_pkg::MODE_OCT: rx = tup_pkg::RX_OCT;
				tup_pkg::MODE_HEX: rx = tup_pkg::RX_HEX;
				default:           rx = tup_pkg::RX_DEC;
			endcase
		end
		case (ph)
			tup_pkg::PH_SPACE: begin
				if (c == tup_pkg::CH_SPACE || (c >= tup_pkg::CH_TAB && c <= tup_pkg::CH_CR)) begin
					// leading whitespace, stay
				end else if (c == tup_pkg::CH_MINUS) begin
					neg = 1'b1;
					ph = tup_pkg::PH_SIGNED;
				end else if (c == tup_pkg::CH_PLUS) begin
					ph = tup_pkg::PH_SIGNED;
				end else begin
					lead_char(c);
				end
			end
			tup_pkg::PH_SIGNED: lead_char(c);
			tup_pkg::PH_ZERO: begin
				if (held == tup_pkg::MODE_AUTO && is_x) begin
					rx = tup_pkg::RX_HEX;
					ph = tup_pkg::PH_DIGITS;
				end else if (held == tup_pkg::MODE_AUTO && is_b) begin
					rx = tup_pkg::RX_BIN;
					ph = tup_pkg::PH_DIGITS;
				end else if ((held == tup_pkg::MODE_HEX && is_x) ||
				             (held == tup_pkg::MODE_BIN && is_b)) begin
					ph = tup_pkg::PH_DIGITS;
				end else begin
					shift_in(c);
				end
			end
			tup_pkg::PH_DIGITS: shift_in(c);
			default: ph = tup_pkg::PH_DONE;
		endcase
		if (last) begin
			if (held > tup_pkg::MODE_HEX) begin
				r.value = '0;
				r.radix_used = tup_pkg::RX_BIN;
				r.bad_base = 1'b1;
			end else begin
				r.radix_used = rx;
				// auto mode that ended before a digit reports decimal
				if (held == tup_pkg::MODE_AUTO &&
				    (ph == tup_pkg::PH_SPACE || ph == tup_pkg::PH_SIGNED))
					r.radix_used = tup_pkg::RX_DEC;
				r.value = neg ? (~acc + 64'd1) : acc;
				r.bad_base = 1'b0;
			end
			expected.push_back(r);
			clear_string();
		end
	endfunction

	// Compare one result word with the oldest expectation
	task check_result(logic [63:0] value, logic [1:0] radix_used, logic bad_base);
		tup_pkg::parse_result_t want;
		if (expected.size() == 0) begin
			report($sformatf("result word value=%h with none expected", value));
			return;
		end
		want = expected.pop_front();
		if (value !== want.value)
			report($sformatf("value %h, expected %h", value, want.value));
		if (radix_used !== want.radix_used)
			report($sformatf("radix_used %0d, expected %0d", radix_used, want.radix_used));
		if (bad_base !== want.bad_base)
			report($sformatf("bad_base %b, expected %b", bad_base, want.bad_base));
	endtask
endclass

module tb_text_to_uint64_parser;

	localparam int         CLK_PERIOD  = 10;
	localparam int         SETTLE      = 4;
	localparam int         DRAIN_LIMIT = 20000;
	localparam int         HOLD_CYCLES = 250;
	localparam logic [2:0] MODE_BAD_LO = 3'd5;
	localparam logic [2:0] MODE_BAD_HI = 3'd7;
	localparam logic [7:0] CH_TOP      = 8'hFF;

	logic clk = 1'b0;
	logic arst_n;

	tup_char_if   chars_if ();
	tup_result_if result_if ();

	text_to_uint64_parser u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.chars  (chars_if),
		.result (result_if)
	);

	parse_scoreboard sb;
	char_word_t      str_buf[$];
	logic [2:0]      cur_mode;
	int              items_sent     = 0;
	int              send_idle_pct  = 0;
	int              recv_stall_pct = 0;
	logic            hold_req       = 1'b0;

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Run limit
	initial begin
		#3_000_000;
		$display("** text_to_uint64_parser: FAILED **");
		$finish;
	end

	// Result side: random stalls, plus one long hold-off when requested
	initial begin
		int hold_left;
		bit hold_taken;
		hold_left = 0;
		hold_taken = 1'b0;
		result_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req && !hold_taken) begin
				hold_taken = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				result_if.ready <= 1'b0;
				hold_left--;
			end else begin
				result_if.ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	// Watch both channels at each edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (chars_if.valid && chars_if.ready)
				sb.note_char(chars_if.ch, chars_if.base_mode, chars_if.first, chars_if.last);
			if (result_if.valid && result_if.ready)
				sb.check_result(result_if.value, result_if.radix_used, result_if.bad_base);
		end
	end

	// Offer one word, with random idle cycles ahead of it
	task send_word(char_word_t w);
		while ($urandom_range(99) < send_idle_pct) begin
			chars_if.valid <= 1'b0;
			@(posedge clk);
		end
		chars_if.valid     <= 1'b1;
		chars_if.ch        <= w.ch;
		chars_if.base_mode <= w.mode;
		chars_if.first     <= w.first;
		chars_if.last      <= w.last;
		do @(posedge clk); while (!chars_if.ready);
		items_sent++;
	endtask

	task send_buf();
		for (int i = 0; i < str_buf.size(); i++) send_word(str_buf[i]);
	endtask

	function automatic void add(logic [7:0] c);
		str_buf.push_back('{ch: c, mode: cur_mode, first: 1'b0, last: 1'b0});
	endfunction

	// Send a literal string, flags on its ends as asked
	task send_text(string s, logic [2:0] mode, logic with_first, logic with_last);
		str_buf.delete();
		cur_mode = mode;
		for (int i = 0; i < s.len(); i++) add(s[i]);
		str_buf[0].first = with_first;
		str_buf[str_buf.size() - 1].last = with_last;
		send_buf();
	endtask

	task put_char(logic [7:0] c, logic [2:0] mode, logic first, logic last);
		send_word('{ch: c, mode: mode, first: first, last: last});
	endtask

	// Stop offering and wait until every expected word has come or DRAIN_LIMIT runs out
	task drain();
		int guard;
		guard = 0;
		chars_if.valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0 && guard < DRAIN_LIMIT) begin
			@(posedge clk);
			guard++;
		end
		repeat (SETTLE) @(posedge clk);
	endtask

	function automatic logic [7:0] digit_char(int unsigned v);
		if (v < 10) return tup_pkg::CH_ZERO + 8'(v);
		return ($urandom_range(1) ? tup_pkg::CH_LA : tup_pkg::CH_UA) + 8'(v - 10);
	endfunction

	function automatic logic [7:0] space_char();
		int unsigned r;
		r = $urandom_range(5);
		return (r == 0) ? tup_pkg::CH_SPACE : tup_pkg::CH_TAB + 8'(r - 1);
	endfunction

	function automatic logic [7:0] noise_char();
		case ($urandom_range(3))
			0: return 8'($urandom_range(255));
			1: return digit_char($urandom_range(15));
			2: return space_char();
			default: begin
				case ($urandom_range(8))
					0: return tup_pkg::CH_PLUS;
					1: return tup_pkg::CH_MINUS;
					2: return tup_pkg::CH_ZERO;
					3: return tup_pkg::CH_LX;
					4: return tup_pkg::CH_UX;
					5: return tup_pkg::CH_LB;
					6: return tup_pkg::CH_UB;
					7: return tup_pkg::CH_NUL;
					default: return CH_TOP;
				endcase
			end
		endcase
	endfunction

	// Build one random string into str_buf
	task build_string();
		int unsigned kind;
		int unsigned r;
		int unsigned ndig;
		int unsigned maxdig;
		int unsigned v;
		int unsigned keep;
		logic [1:0]  dr;
		logic        lead_nz;
		char_word_t  w;
		str_buf.delete();
		kind = $urandom_range(99);
		cur_mode = 3'($urandom_range(7));
		// noise: random bytes and stray flags
		if (kind < 20) begin
			ndig = $urandom_range(1, 8);
			for (int i = 0; i < ndig; i++) begin
				add(noise_char());
				str_buf[i].first = (i == 0) ? ($urandom_range(9) != 0) : ($urandom_range(19) == 0);
				str_buf[i].last = (i == ndig - 1) || ($urandom_range(19) == 0);
			end
			return;
		end
		r = $urandom_range(99);
		if (r < 30)      cur_mode = tup_pkg::MODE_AUTO;
		else if (r < 45) cur_mode = tup_pkg::MODE_BIN;
		else if (r < 60) cur_mode = tup_pkg::MODE_OCT;
		else if (r < 75) cur_mode = tup_pkg::MODE_DEC;
		else if (r < 95) cur_mode = tup_pkg::MODE_HEX;
		else             cur_mode = 3'($urandom_range(MODE_BAD_LO, MODE_BAD_HI));
		repeat ($urandom_range(2)) add(space_char());
		case ($urandom_range(2))
			0: add(tup_pkg::CH_MINUS);
			1: add(tup_pkg::CH_PLUS);
			default: ;
		endcase
		lead_nz = 1'b0;
		case (cur_mode)
			tup_pkg::MODE_AUTO: begin
				case ($urandom_range(3))
					0: begin
						add(tup_pkg::CH_ZERO);
						add($urandom_range(1) ? tup_pkg::CH_LX : tup_pkg::CH_UX);
						dr = tup_pkg::RX_HEX;
					end
					1: begin
						add(tup_pkg::CH_ZERO);
						add($urandom_range(1) ? tup_pkg::CH_LB : tup_pkg::CH_UB);
						dr = tup_pkg::RX_BIN;
					end
					2: begin
						add(tup_pkg::CH_ZERO);
						dr = tup_pkg::RX_OCT;
					end
					default: begin
						dr = tup_pkg::RX_DEC;
						lead_nz = 1'b1;
					end
				endcase
			end
			tup_pkg::MODE_BIN: begin
				dr = tup_pkg::RX_BIN;
				if ($urandom_range(1)) begin
					add(tup_pkg::CH_ZERO);
					add($urandom_range(1) ? tup_pkg::CH_LB : tup_pkg::CH_UB);
				end
			end
			tup_pkg::MODE_OCT: dr = tup_pkg::RX_OCT;
			tup_pkg::MODE_HEX: begin
				dr = tup_pkg::RX_HEX;
				if ($urandom_range(1)) begin
					add(tup_pkg::CH_ZERO);
					add($urandom_range(1) ? tup_pkg::CH_LX : tup_pkg::CH_UX);
				end
			end
			default: dr = tup_pkg::RX_DEC;
		endcase
		// digits, now and then long enough to wrap past 64 bits
		case (dr)
			tup_pkg::RX_BIN: maxdig = 70;
			tup_pkg::RX_OCT: maxdig = 24;
			tup_pkg::RX_DEC: maxdig = 22;
			default:         maxdig = 18;
		endcase
		ndig = ($urandom_range(4) == 0) ? $urandom_range(1, maxdig) : $urandom_range(1, 6);
		for (int i = 0; i < ndig; i++) begin
			if (lead_nz && i == 0) v = $urandom_range(1, 9);
			else v = $urandom_range(radix_count(dr) - 1);
			add(digit_char(v));
		end
		if ($urandom_range(4) == 0) begin
			add(noise_char());
			repeat ($urandom_range(2)) add(noise_char());
		end
		str_buf[0].first = 1'b1;
		str_buf[str_buf.size() - 1].last = 1'b1;
		// broken strings
		if (kind < 35) begin
			case ($urandom_range(3))
				0: str_buf[0].first = 1'b0;
				1: str_buf[str_buf.size() - 1].last = 1'b0;
				2: begin
					keep = $urandom_range(1, 3);
					while (str_buf.size() > keep) void'(str_buf.pop_back());
					str_buf[str_buf.size() - 1].last = 1'b1;
				end
				default: begin
					if (str_buf.size() > 1) begin
						w = '{ch: tup_pkg::CH_SPACE, mode: cur_mode, first: 1'b0, last: 1'b0};
						str_buf.insert(1, w);
					end
				end
			endcase
		end
	endtask

	task run_random(int target);
		while (items_sent < target) begin
			build_string();
			send_buf();
		end
	endtask

	// Main sequence
	initial begin
		sb = new();
		arst_n             <= 1'b0;
		chars_if.valid     <= 1'b0;
		chars_if.ch        <= tup_pkg::CH_NUL;
		chars_if.base_mode <= tup_pkg::MODE_AUTO;
		chars_if.first     <= 1'b0;
		chars_if.last      <= 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: no first after reset keeps auto, the mode is ignored
		send_text("7", MODE_BAD_LO, 1'b0, 1'b1);
		// carry on after a result without first; sign alone reports decimal
		send_text("-", tup_pkg::MODE_AUTO, 1'b0, 1'b1);
		send_text("1", MODE_BAD_HI, 1'b1, 1'b1);
		// lone zero in auto mode reports octal
		send_text("0", tup_pkg::MODE_AUTO, 1'b1, 1'b1);
		send_text("0x1F", tup_pkg::MODE_AUTO, 1'b1, 1'b1);
		// in hex mode "0b" is plain hex digits
		send_text("0b1", tup_pkg::MODE_HEX, 1'b1, 1'b1);
		// minus one gives all ones
		send_text("-0b1", tup_pkg::MODE_BIN, 1'b1, 1'b1);
		// whitespace after the sign stops the number
		send_text("+ 5", tup_pkg::MODE_DEC, 1'b1, 1'b1);
		put_char(tup_pkg::CH_CR, tup_pkg::MODE_OCT, 1'b1, 1'b0);
		put_char(tup_pkg::CH_ZERO + 8'd7, tup_pkg::MODE_OCT, 1'b0, 1'b0);
		put_char(CH_TOP, tup_pkg::MODE_OCT, 1'b0, 1'b1);
		// NUL ends the digits
		put_char(tup_pkg::CH_ZERO + 8'd1, tup_pkg::MODE_DEC, 1'b1, 1'b0);
		put_char(tup_pkg::CH_NUL, tup_pkg::MODE_DEC, 1'b0, 1'b0);
		put_char(tup_pkg::CH_ZERO + 8'd3, tup_pkg::MODE_DEC, 1'b0, 1'b1);

		// no idling, with one long result hold-off that backs up the input
		hold_req = 1'b1;
		run_random(480);
		drain();

		send_idle_pct = 59;
		recv_stall_pct = 0;
		run_random(940);
		drain();

		send_idle_pct = 0;
		recv_stall_pct = 59;
		run_random(1400);
		drain();

		send_idle_pct = 37;
		recv_stall_pct = 37;
		run_random(1870);
		drain();

		if (sb.pending() != 0)
			sb.report($sformatf("%0d result words never came", sb.pending()));
		if (sb.errors == 0) begin
			$display("** text_to_uint64_parser: PASSED **");
		end else begin
			$display("** text_to_uint64_parser: FAILED **");
		end
		$finish;
	end

endmodule
